[src/bpc_pkg.sv]
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int DT_W    = 25;
   localparam int PROD_W  = 42;
   localparam int SQ_W    = 50;
   localparam int TEMP1_W = 19;
   localparam int TEMP_W  = 20;
   localparam int WIDE_W  = 40;
   localparam int T2_W    = 17;
   localparam int SQR_W   = 38;
   localparam int PRESS_W = 26;
   localparam int CSR_W   = 3;

   localparam logic signed [TEMP1_W-1:0] TEMP_REF_CENTIDEG = 19'sd2000;
   localparam logic signed [TEMP1_W-1:0] TEMP_VERY_COLD    = -19'sd1500;
   localparam logic signed [TEMP1_W-1:0] VERY_COLD_SHIFT   =
      TEMP_REF_CENTIDEG - TEMP_VERY_COLD;

   localparam logic signed [WIDE_W-1:0] OFF2_A_COEF  = 40'sd5;
   localparam logic signed [WIDE_W-1:0] OFF2_B_COEF  = 40'sd7;
   localparam logic signed [WIDE_W-1:0] SENS2_B_COEF = 40'sd11;

   localparam logic signed [PRESS_W-1:0] PRESS_MIN = -26'sd33554432;
   localparam logic signed [PRESS_W-1:0] PRESS_MAX = 26'sd33554431;

   typedef enum logic [CSR_W-1:0] {
      CSR_PRESS_SENS,
      CSR_PRESS_OFF,
      CSR_SENS_TC,
      CSR_OFF_TC,
      CSR_TEMP_REF,
      CSR_TEMP_SLOPE
   } bpc_csr_type;

   typedef struct packed {
      logic [CAL_W-1:0] press_sens;
      logic [CAL_W-1:0] press_off;
      logic [CAL_W-1:0] sens_tc;
      logic [CAL_W-1:0] off_tc;
      logic [CAL_W-1:0] temp_ref;
      logic [CAL_W-1:0] temp_slope;
   } bpc_cal_type;

   typedef struct packed {
      logic [RAW_W-1:0]          d1;
      logic signed [TEMP1_W-1:0] temp1;
      logic signed [TEMP1_W-1:0] a;
      logic signed [TEMP1_W-1:0] b;
      logic signed [WIDE_W-1:0]  off1;
      logic signed [WIDE_W-1:0]  sens1;
      logic [T2_W-1:0]           t2;
   } bpc_first_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TEMP_W-1:0] temp;
      logic signed [WIDE_W-1:0] off;
      logic signed [WIDE_W-1:0] sens;
   } bpc_second_type;

endpackage

[src/bpc_front.sv]
`timescale 1ns / 1ps

module bpc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  bpc_pkg::bpc_cal_type    cal,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [bpc_pkg::RAW_W-1:0] in_pressure,
   input  logic [bpc_pkg::RAW_W-1:0] in_temperature,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bpc_pkg::bpc_first_type  out_item
);

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy;

   logic signed [bpc_pkg::DT_W-1:0]   dt_in, dt_ff;
   logic [bpc_pkg::RAW_W-1:0]         d1_s1_ff, d1_s2_ff;
   logic signed [bpc_pkg::PROD_W-1:0] pt_in, pt_ff;
   logic signed [bpc_pkg::PROD_W-1:0] poff_in, poff_ff;
   logic signed [bpc_pkg::PROD_W-1:0] psens_in, psens_ff;
   logic signed [bpc_pkg::SQ_W-1:0]   pdd_in, pdd_ff;
   logic signed [bpc_pkg::TEMP1_W-1:0] a_in;
   bpc_pkg::bpc_first_type            s3_in, s3_ff;

   assign s3_rdy   = !s3_vld_ff || out_ready;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;
   assign in_ready = s1_rdy;
   assign out_valid = s3_vld_ff;
   assign out_item  = s3_ff;

   assign dt_in = $signed({1'b0, in_temperature}) - $signed({1'b0, cal.temp_ref, 8'h00});

   assign pt_in    = dt_ff * $signed({1'b0, cal.temp_slope});
   assign poff_in  = dt_ff * $signed({1'b0, cal.off_tc});
   assign psens_in = dt_ff * $signed({1'b0, cal.sens_tc});
   assign pdd_in   = dt_ff * dt_ff;

   assign a_in = $signed(pt_ff[bpc_pkg::PROD_W-1:23]);

   always_comb begin
      s3_in.d1    = d1_s2_ff;
      s3_in.a     = a_in;
      s3_in.temp1 = a_in + bpc_pkg::TEMP_REF_CENTIDEG;
      s3_in.b     = a_in + bpc_pkg::VERY_COLD_SHIFT;
      s3_in.off1  = $signed({8'd0, cal.press_off, 16'd0})
                    + 40'($signed(poff_ff[bpc_pkg::PROD_W-1:7]));
      s3_in.sens1 = $signed({9'd0, cal.press_sens, 15'd0})
                    + 40'($signed(psens_ff[bpc_pkg::PROD_W-1:8]));
      s3_in.t2    = pdd_ff[47:31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= in_valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         dt_ff    <= dt_in;
         d1_s1_ff <= in_pressure;
      end
      if (s2_rdy) begin
         pt_ff    <= pt_in;
         poff_ff  <= poff_in;
         psens_ff <= psens_in;
         pdd_ff   <= pdd_in;
         d1_s2_ff <= d1_s1_ff;
      end
      if (s3_rdy) begin
         s3_ff <= s3_in;
      end
   end

endmodule

[src/bpc_second.sv]
`timescale 1ns / 1ps

module bpc_second (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  bpc_pkg::bpc_first_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output bpc_pkg::bpc_second_type out_item
);

   logic s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic s4_rdy, s5_rdy, s6_rdy;

   bpc_pkg::bpc_first_type             s4_ff;
   logic signed [bpc_pkg::SQR_W-1:0]   a2_in, a2_ff;
   logic signed [bpc_pkg::SQR_W-1:0]   b2_in, b2_ff;
   logic                               cold_ff, vcold_ff;

   logic signed [bpc_pkg::WIDE_W-1:0]  a2x, b2x, a5, b7, b11;
   logic signed [bpc_pkg::WIDE_W-1:0]  off2_in, off2_ff;
   logic signed [bpc_pkg::WIDE_W-1:0]  sens2_in, sens2_ff;
   logic signed [bpc_pkg::TEMP_W-1:0]  temp_in, temp_s5_ff;
   logic signed [bpc_pkg::WIDE_W-1:0]  off1_s5_ff, sens1_s5_ff;
   logic [bpc_pkg::RAW_W-1:0]          d1_s5_ff;
   bpc_pkg::bpc_second_type            s6_in, s6_ff;

   assign s6_rdy    = !s6_vld_ff || out_ready;
   assign s5_rdy    = !s5_vld_ff || s6_rdy;
   assign s4_rdy    = !s4_vld_ff || s5_rdy;
   assign in_ready  = s4_rdy;
   assign out_valid = s6_vld_ff;
   assign out_item  = s6_ff;

   assign a2_in = in_data.a * in_data.a;
   assign b2_in = in_data.b * in_data.b;

   assign a2x = 40'(a2_ff);
   assign b2x = 40'(b2_ff);
   assign a5  = a2x * bpc_pkg::OFF2_A_COEF;
   assign b7  = b2x * bpc_pkg::OFF2_B_COEF;
   assign b11 = b2x * bpc_pkg::SENS2_B_COEF;

   always_comb begin
      off2_in  = '0;
      sens2_in = '0;
      if (vcold_ff) begin
         off2_in  = (a5 >>> 1) + b7;
         sens2_in = (a5 >>> 2) + (b11 >>> 1);
      end else if (cold_ff) begin
         off2_in  = a5 >>> 1;
         sens2_in = a5 >>> 2;
      end
   end

   assign temp_in = 20'(s4_ff.temp1)
                    - (cold_ff ? $signed({3'b000, s4_ff.t2}) : 20'sd0);

   always_comb begin
      s6_in.d1   = d1_s5_ff;
      s6_in.temp = temp_s5_ff;
      s6_in.off  = off1_s5_ff - off2_ff;
      s6_in.sens = sens1_s5_ff - sens2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         if (s4_rdy) s4_vld_ff <= in_valid;
         if (s5_rdy) s5_vld_ff <= s4_vld_ff;
         if (s6_rdy) s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_ff    <= in_data;
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
         cold_ff  <= in_data.a < 0;
         vcold_ff <= in_data.b < 0;
      end
      if (s5_rdy) begin
         off2_ff     <= off2_in;
         sens2_ff    <= sens2_in;
         temp_s5_ff  <= temp_in;
         off1_s5_ff  <= s4_ff.off1;
         sens1_s5_ff <= s4_ff.sens1;
         d1_s5_ff    <= s4_ff.d1;
      end
      if (s6_rdy) begin
         s6_ff <= s6_in;
      end
   end

endmodule

[src/bpc_press.sv]
`timescale 1ns / 1ps

module bpc_press (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  bpc_pkg::bpc_second_type             in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [bpc_pkg::TEMP_W-1:0]   out_temp,
   output logic signed [bpc_pkg::PRESS_W-1:0]  out_press
);

   logic s7_vld_ff, s8_vld_ff, s9_vld_ff;
   logic s7_rdy, s8_rdy, s9_rdy;

   logic [43:0]                        pl_in, pl_ff;
   logic signed [44:0]                 ph_in, ph_ff;
   logic signed [bpc_pkg::TEMP_W-1:0]  temp_s7_ff, temp_s8_ff, temp_s9_ff;
   logic signed [bpc_pkg::WIDE_W-1:0]  off_s7_ff, off_s8_ff;
   logic signed [63:0]                 prod_in, prod_ff;
   logic signed [42:0]                 x_in;
   logic [27:0]                        p28;
   logic signed [bpc_pkg::PRESS_W-1:0] press_in, press_ff;

   assign s9_rdy    = !s9_vld_ff || out_ready;
   assign s8_rdy    = !s8_vld_ff || s9_rdy;
   assign s7_rdy    = !s7_vld_ff || s8_rdy;
   assign in_ready  = s7_rdy;
   assign out_valid = s9_vld_ff;
   assign out_temp  = temp_s9_ff;
   assign out_press = press_ff;

   assign pl_in = in_data.d1 * in_data.sens[19:0];
   assign ph_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);

   assign prod_in = (64'(ph_ff) <<< 20) + $signed({20'd0, pl_ff});

   assign x_in = $signed(prod_ff[63:21]) - 43'(off_s8_ff);
   assign p28  = x_in[42:15];

   always_comb begin
      if ((p28[27:25] == 3'b000) || (p28[27:25] == 3'b111)) begin
         press_in = $signed(p28[25:0]);
      end else if (p28[27]) begin
         press_in = bpc_pkg::PRESS_MIN;
      end else begin
         press_in = bpc_pkg::PRESS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_vld_ff <= 1'b0;
         s8_vld_ff <= 1'b0;
         s9_vld_ff <= 1'b0;
      end else begin
         if (s7_rdy) s7_vld_ff <= in_valid;
         if (s8_rdy) s8_vld_ff <= s7_vld_ff;
         if (s9_rdy) s9_vld_ff <= s8_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s7_rdy) begin
         pl_ff      <= pl_in;
         ph_ff      <= ph_in;
         temp_s7_ff <= in_data.temp;
         off_s7_ff  <= in_data.off;
      end
      if (s8_rdy) begin
         prod_ff    <= prod_in;
         temp_s8_ff <= temp_s7_ff;
         off_s8_ff  <= off_s7_ff;
      end
      if (s9_rdy) begin
         press_ff   <= press_in;
         temp_s9_ff <= temp_s8_ff;
      end
   end

endmodule

[src/baro_pressure_temp_compensation_unit.sv]
`timescale 1ns / 1ps
// Each transaction passes stages s1-s9 in order (front, second, press) before rsp_tvalid.
// Nine-stage multiply pipeline: one transaction per cycle while rsp_tready is high.
// Every stage holds its own valid bit; a stalled stage keeps its item and fills bubbles.
// Reset (synchronous, active high) clears all valid bits and the six calibration words.

module baro_pressure_temp_compensation_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [23:0] raw_pressure, [47:24] raw_temperature
   input  logic [47:0]               req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [19:0] temperature_centideg, [45:20] pressure_comp, [47:46] zero
   output logic [47:0]               rsp_tdata,
   input  logic                      csr_wen,
   input  logic [bpc_pkg::CSR_W-1:0] csr_addr,
   input  logic [bpc_pkg::CAL_W-1:0] csr_wdata
);

   bpc_pkg::bpc_cal_type   cal_ff;
   bpc_pkg::bpc_first_type first_data;
   bpc_pkg::bpc_second_type second_data;
   logic first_vld, first_rdy, second_vld, second_rdy;
   logic signed [bpc_pkg::TEMP_W-1:0]  temp_out;
   logic signed [bpc_pkg::PRESS_W-1:0] press_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_wen) begin
         unique case (bpc_pkg::bpc_csr_type'(csr_addr))
            bpc_pkg::CSR_PRESS_SENS: cal_ff.press_sens <= csr_wdata;
            bpc_pkg::CSR_PRESS_OFF:  cal_ff.press_off  <= csr_wdata;
            bpc_pkg::CSR_SENS_TC:    cal_ff.sens_tc    <= csr_wdata;
            bpc_pkg::CSR_OFF_TC:     cal_ff.off_tc     <= csr_wdata;
            bpc_pkg::CSR_TEMP_REF:   cal_ff.temp_ref   <= csr_wdata;
            bpc_pkg::CSR_TEMP_SLOPE: cal_ff.temp_slope <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bpc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cal            (cal_ff),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_pressure    (req_tdata[23:0]),
      .in_temperature (req_tdata[47:24]),
      .out_valid      (first_vld),
      .out_ready      (first_rdy),
      .out_item       (first_data)
   );

   bpc_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_vld),
      .in_ready  (first_rdy),
      .in_data   (first_data),
      .out_valid (second_vld),
      .out_ready (second_rdy),
      .out_item  (second_data)
   );

   bpc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (second_vld),
      .in_ready  (second_rdy),
      .in_data   (second_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (temp_out),
      .out_press (press_out)
   );

   assign rsp_tdata = {2'b00, press_out, temp_out};

endmodule
